// ----- rtl/psbag_pkg.sv -----
package psbag_pkg;

    // register field widths
    localparam int WIDTH_W = 11;
    localparam int HEIGHT_W = 11;
    localparam int OFS_W = 10;
    localparam int DEST_W = 12;
    localparam int SCALE_W = 3;
    localparam int PITCH_W = 13;
    localparam int PLANE_W = WIDTH_W - 2;

    // register indexes
    localparam logic [2:0] REG_ORIG_WIDTH = 3'd0;
    localparam logic [2:0] REG_ORIG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SRC_X = 3'd2;
    localparam logic [2:0] REG_SRC_Y = 3'd3;
    localparam logic [2:0] REG_DEST_X = 3'd4;
    localparam logic [2:0] REG_DEST_Y = 3'd5;
    localparam logic [2:0] REG_SCALE = 3'd6;
    localparam logic [2:0] REG_LINE_PITCH = 3'd7;

    // access kinds on the output stream
    localparam logic KIND_SRC_READ = 1'b0;
    localparam logic KIND_DST_WRITE = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    typedef struct packed {
        logic [WIDTH_W-1:0]  orig_width;
        logic [HEIGHT_W-1:0] orig_height;
        logic [OFS_W-1:0]    src_x;
        logic [OFS_W-1:0]    src_y;
        logic [DEST_W-1:0]   dest_x;
        logic [DEST_W-1:0]   dest_y;
        logic [SCALE_W-1:0]  scale;
        logic [PITCH_W-1:0]  line_pitch;
    } t_cfg;

    // zero counts as one, anything above the limit is clipped
    function automatic logic [SCALE_W-1:0] sat_scale(input logic [SCALE_W-1:0] s,
                                                     input logic [SCALE_W-1:0] mx);
        logic [SCALE_W-1:0] r;
        r = s;
        if (r == '0) begin
            r = SCALE_W'(1);
        end
        if (r > mx) begin
            r = mx;
        end
        return r;
    endfunction

endpackage

// ----- rtl/psbag_cfg.sv -----
module psbag_cfg
    import psbag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;

    assign w_idx = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orig_width <= WIDTH_W'(320);
            r_cfg.orig_height <= HEIGHT_W'(200);
            r_cfg.src_x <= '0;
            r_cfg.src_y <= '0;
            r_cfg.dest_x <= '0;
            r_cfg.dest_y <= '0;
            r_cfg.scale <= SCALE_W'(1);
            r_cfg.line_pitch <= PITCH_W'(320);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_ORIG_WIDTH: r_cfg.orig_width <= pwdata[WIDTH_W-1:0];
                REG_ORIG_HEIGHT: r_cfg.orig_height <= pwdata[HEIGHT_W-1:0];
                REG_SRC_X: r_cfg.src_x <= pwdata[OFS_W-1:0];
                REG_SRC_Y: r_cfg.src_y <= pwdata[OFS_W-1:0];
                REG_DEST_X: r_cfg.dest_x <= pwdata[DEST_W-1:0];
                REG_DEST_Y: r_cfg.dest_y <= pwdata[DEST_W-1:0];
                REG_SCALE: r_cfg.scale <= pwdata[SCALE_W-1:0];
                REG_LINE_PITCH: r_cfg.line_pitch <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_ORIG_WIDTH: prdata = 32'(r_cfg.orig_width);
            REG_ORIG_HEIGHT: prdata = 32'(r_cfg.orig_height);
            REG_SRC_X: prdata = 32'(r_cfg.src_x);
            REG_SRC_Y: prdata = 32'(r_cfg.src_y);
            REG_DEST_X: prdata = 32'(r_cfg.dest_x);
            REG_DEST_Y: prdata = 32'(r_cfg.dest_y);
            REG_SCALE: prdata = 32'(r_cfg.scale);
            REG_LINE_PITCH: prdata = 32'(r_cfg.line_pitch);
            default: prdata = '0;
        endcase
    end

endmodule

// ----- rtl/psbag_front.sv -----
module psbag_front
    import psbag_pkg::*;
#(
    parameter int ADDR_BITS = 24,
    parameter int COORD_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic [SCALE_W-1:0]     i_scale,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_BITS-1:0]  i_col,
    input  logic [COORD_BITS-1:0]  i_row,
    input  logic [QLVL_W-1:0]      i_q_level,
    output logic                   o_push,
    output logic [2*ADDR_BITS-1:0] o_push_data
);

    localparam int CW = ((COORD_BITS > OFS_W) ? COORD_BITS : OFS_W) + 1;
    localparam int PW = CW + PLANE_W;
    localparam int QHW = PLANE_W + HEIGHT_W;
    localparam int LW = ((COORD_BITS + SCALE_W > DEST_W) ? COORD_BITS + SCALE_W : DEST_W) + 1;
    localparam int SW = ((PW > QHW + 1) ? PW : QHW + 1) + 2;
    localparam int DW = LW + PITCH_W + 1;

    logic               r_v;
    logic [PW-1:0]      r_p1;
    logic [QHW-1:0]     r_qh;
    logic [CW-1:0]      r_c;
    logic [LW-1:0]      r_line0;
    logic [LW-1:0]      r_dcol;

    logic [PLANE_W-1:0] w_q;
    logic [CW-1:0]      w_ry;
    logic               w_take;
    logic [SW-1:0]      w_plane_ofs;
    logic [SW-1:0]      w_src;
    logic [DW-1:0]      w_dst;

    // room left for the item in flight and the new one
    assign o_ready = (i_q_level + QLVL_W'(r_v)) < QLVL_W'(QUEUE_DEPTH);
    assign w_take = i_valid && o_ready;

    assign w_q = i_cfg.orig_width[WIDTH_W-1:2];
    assign w_ry = CW'(i_row) + CW'(i_cfg.src_y);

    // stage one: products of coordinates and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= PW'(w_ry) * PW'(w_q);
        r_qh <= QHW'(w_q) * QHW'(i_cfg.orig_height);
        r_c <= CW'(i_col) + CW'(i_cfg.src_x);
        r_line0 <= LW'(i_row) * LW'(i_scale) + LW'(i_cfg.dest_y);
        r_dcol <= LW'(i_col) * LW'(i_scale) + LW'(i_cfg.dest_x);
    end

    // stage two: plane offset, source sum and first destination address
    assign w_plane_ofs = (r_c[1] ? SW'({r_qh, 1'b0}) : '0) + (r_c[0] ? SW'(r_qh) : '0);
    assign w_src = SW'(r_p1) + SW'(r_c[CW-1:2]) + w_plane_ofs;
    assign w_dst = DW'(r_line0) * DW'(i_cfg.line_pitch) + DW'(r_dcol);

    assign o_push = r_v;
    assign o_push_data = {ADDR_BITS'(w_dst), ADDR_BITS'(w_src)};

endmodule

// ----- rtl/psbag_queue.sv -----
module psbag_queue
    import psbag_pkg::*;
#(
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic [QLVL_W-1:0] o_level
);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QLVL_W-1:0] r_level;

    assign o_data = r_mem[r_rd];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_level <= r_level + QLVL_W'(i_push) - QLVL_W'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/psbag_back.sv -----
module psbag_back
    import psbag_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SCALE_W-1:0]     i_scale,
    input  logic [PITCH_W-1:0]     i_pitch,
    input  logic                   i_q_empty,
    input  logic [2*ADDR_BITS-1:0] i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ADDR_BITS-1:0]   o_addr,
    output logic                   o_kind,
    output logic                   o_last
);

    logic                 r_active, n_active;
    logic [SCALE_W-1:0]   r_m, n_m;
    logic [SCALE_W-1:0]   r_n, n_n;
    logic [ADDR_BITS-1:0] r_cur, n_cur;
    logic [ADDR_BITS-1:0] r_row, n_row;
    logic                 r_o_valid, n_o_valid;
    logic [ADDR_BITS-1:0] r_o_addr, n_o_addr;
    logic                 r_o_kind, n_o_kind;
    logic                 r_o_last, n_o_last;

    logic                 w_free;
    logic [SCALE_W-1:0]   w_top;
    logic                 w_fin;
    logic [ADDR_BITS-1:0] w_next_row;

    assign w_free = !r_o_valid || i_ready;
    assign w_top = i_scale - SCALE_W'(1);
    assign w_fin = (r_m == w_top) && (r_n == w_top);
    assign w_next_row = r_row + ADDR_BITS'(i_pitch);

    // walk one address per cycle while the output is free: source read, then the destination block
    always_comb begin
        n_active = r_active;
        n_m = r_m;
        n_n = r_n;
        n_cur = r_cur;
        n_row = r_row;
        n_o_valid = r_o_valid;
        n_o_addr = r_o_addr;
        n_o_kind = r_o_kind;
        n_o_last = r_o_last;
        o_pop = 1'b0;
        if (w_free) begin
            if (r_active) begin
                n_o_valid = 1'b1;
                n_o_addr = r_cur;
                n_o_kind = KIND_DST_WRITE;
                n_o_last = w_fin;
                if (w_fin) begin
                    n_active = 1'b0;
                end else if (r_n == w_top) begin
                    n_n = '0;
                    n_m = r_m + SCALE_W'(1);
                    n_row = w_next_row;
                    n_cur = w_next_row;
                end else begin
                    n_n = r_n + SCALE_W'(1);
                    n_cur = r_cur + ADDR_BITS'(1);
                end
            end else if (!i_q_empty) begin
                o_pop = 1'b1;
                n_o_valid = 1'b1;
                n_o_addr = i_q_data[ADDR_BITS-1:0];
                n_o_kind = KIND_SRC_READ;
                n_o_last = 1'b0;
                n_active = 1'b1;
                n_m = '0;
                n_n = '0;
                n_cur = i_q_data[2*ADDR_BITS-1:ADDR_BITS];
                n_row = i_q_data[2*ADDR_BITS-1:ADDR_BITS];
            end else begin
                n_o_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
        r_n <= n_n;
        r_cur <= n_cur;
        r_row <= n_row;
        r_o_addr <= n_o_addr;
        r_o_kind <= n_o_kind;
        r_o_last <= n_o_last;
    end

    assign o_valid = r_o_valid;
    assign o_addr = r_o_addr;
    assign o_kind = r_o_kind;
    assign o_last = r_o_last;

endmodule

// ----- rtl/planar_scaled_blit_address_gen.sv -----
// Blit address generator for a four-plane source image. Each input transfer names one
// pixel of the copied rectangle (column in the low bits, row above it). For every pixel
// the output stream carries first the plane-interleaved source read address (tuser 0),
// then scale*scale destination write addresses (tuser 1), row by row, with tlast on the
// final one. Addresses wrap at ADDR_BITS. The output emits one address per cycle while
// the receiver is ready; the back-end address walker pops the next pixel only after the
// last destination address of the current one. The front end takes one pixel per cycle
// while the queue has room, through two stages of multiplies into a four-entry queue and
// on to the output register. Registers sit on the APB port at byte address 4*index and
// may be written only while the block is idle.
module planar_scaled_blit_address_gen
    import psbag_pkg::*;
#(
    parameter int ADDR_BITS = 24,
    parameter int COORD_BITS = 10,
    parameter int MAX_SCALE = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [4:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // col_index, row_index
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // address
    output logic [((ADDR_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    // access_kind
    output logic [0:0]                            o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);

    localparam int OUT_W = ((ADDR_BITS + 7) / 8) * 8;

    t_cfg                   w_cfg;
    logic [SCALE_W-1:0]     w_scale;
    logic                   w_push;
    logic [2*ADDR_BITS-1:0] w_push_data;
    logic                   w_pop;
    logic [2*ADDR_BITS-1:0] w_q_data;
    logic                   w_q_empty;
    logic [QLVL_W-1:0]      w_q_level;
    logic [ADDR_BITS-1:0]   w_addr;
    logic                   w_kind;

    // register file
    psbag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // effective magnification
    assign w_scale = sat_scale(w_cfg.scale, SCALE_W'(MAX_SCALE));

    // front end: address precompute per pixel
    psbag_front #(
        .ADDR_BITS  (ADDR_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_scale     (w_scale),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_col       (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_row       (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_q_level   (w_q_level),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // queue between front and back
    psbag_queue #(
        .DATA_W (2 * ADDR_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty),
        .o_level (w_q_level)
    );

    // back end: address walker and output register
    psbag_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_scale   (w_scale),
        .i_pitch   (w_cfg.line_pitch),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_addr    (w_addr),
        .o_kind    (w_kind),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'(w_addr);
    assign o_m_axis_tuser = w_kind;

endmodule

// ----- tb/tb.sv -----
module tb
    import psbag_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS = 24;
    localparam int COORD_BITS = 10;
    localparam int MAX_SCALE = 7;
    localparam int IN_W = ((2*COORD_BITS+7)/8)*8;
    localparam int OUT_W = ((ADDR_BITS+7)/8)*8;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_PHASES = 10;
    localparam int PIXELS_PER_PHASE = 37;
    localparam int IDLE_PCT = 18;
    localparam int SETTLE_CYCLES = 6;

    // one address the output stream should carry
    typedef struct {
        logic                 kind;
        logic [ADDR_BITS-1:0] addr;
        logic                 last;
    } t_addr_beat;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} t_row_kind;

    // directed stimulus row: a register write or a pixel, optionally with known addresses
    typedef struct {
        t_row_kind             kind;
        logic [2:0]            reg_idx;
        logic [31:0]           value;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        bit                    known;
        logic [ADDR_BITS-1:0]  src_addr;
        logic [ADDR_BITS-1:0]  dst_addr;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic [0:0]        o_m_axis_tuser;
    logic              o_m_axis_tlast;

    t_addr_beat        pending_addrs[$];
    t_cfg              cfg_mirror;
    int                mismatch_count;
    bit                no_idle;
    bit                cur_known;
    logic [ADDR_BITS-1:0] cur_src;
    logic [ADDR_BITS-1:0] cur_dst;
    t_dir_row          dir_table [NUM_DIRECTED];

    planar_scaled_blit_address_gen #(
        .ADDR_BITS(ADDR_BITS),
        .COORD_BITS(COORD_BITS),
        .MAX_SCALE(MAX_SCALE)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser),
        .o_m_axis_tlast(o_m_axis_tlast)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // source read address followed by the scale x scale destination writes of one pixel
    function automatic void predict_pixel_addrs(input logic [COORD_BITS-1:0] col,
                                                input logic [COORD_BITS-1:0] row);
        logic [63:0] s;
        logic [63:0] stride;
        logic [63:0] c;
        logic [63:0] src;
        logic [63:0] line;
        logic [63:0] dst;
        t_addr_beat  beat;
        s = 64'(cfg_mirror.scale);
        if (s == 0) begin
            s = 1;
        end
        if (s > MAX_SCALE) begin
            s = MAX_SCALE;
        end
        stride = 64'(cfg_mirror.orig_width) >> 2;
        c = 64'(col) + 64'(cfg_mirror.src_x);
        src = (64'(row) + 64'(cfg_mirror.src_y)) * stride + (c >> 2)
            + (c & 64'd3) * stride * 64'(cfg_mirror.orig_height);
        beat.kind = KIND_SRC_READ;
        beat.addr = src[ADDR_BITS-1:0];
        beat.last = 1'b0;
        pending_addrs.push_back(beat);
        for (int m = 0; m < s; m++) begin
            for (int n = 0; n < s; n++) begin
                line = 64'(row) * s + 64'(m) + 64'(cfg_mirror.dest_y);
                dst = line * 64'(cfg_mirror.line_pitch) + 64'(col) * s + 64'(n)
                    + 64'(cfg_mirror.dest_x);
                beat.kind = KIND_DST_WRITE;
                beat.addr = dst[ADDR_BITS-1:0];
                beat.last = (m == s - 1) && (n == s - 1);
                pending_addrs.push_back(beat);
            end
        end
    endfunction

    // input transfers feed the predictor, output transfers are checked in order
    always @(posedge i_clk) begin
        t_addr_beat want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (cur_known) begin
                    pending_addrs.push_back(t_addr_beat'{KIND_SRC_READ, cur_src, 1'b0});
                    pending_addrs.push_back(t_addr_beat'{KIND_DST_WRITE, cur_dst, 1'b1});
                end else begin
                    predict_pixel_addrs(i_s_axis_tdata[COORD_BITS-1:0],
                                        i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_addrs.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transfer kind %0d addr %h last %0d", $time,
                             o_m_axis_tuser[0], o_m_axis_tdata[ADDR_BITS-1:0],
                             o_m_axis_tlast);
                end else begin
                    want = pending_addrs.pop_front();
                    if (o_m_axis_tuser[0] !== want.kind
                        || o_m_axis_tdata !== OUT_W'(want.addr)
                        || o_m_axis_tlast !== want.last) begin
                        mismatch_count++;
                        $display("%0t: expected kind/addr/last %0d/%h/%0d, got %0d/%h/%0d",
                                 $time, want.kind, want.addr, want.last, o_m_axis_tuser[0],
                                 o_m_axis_tdata, o_m_axis_tlast);
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // let every expected address come out, then a few settle cycles
    task automatic drain_outputs();
        i_s_axis_tvalid = 1'b0;
        while (pending_addrs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write: setup then access cycle, mirror follows at the write edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ORIG_WIDTH:  cfg_mirror.orig_width = val[WIDTH_W-1:0];
            REG_ORIG_HEIGHT: cfg_mirror.orig_height = val[HEIGHT_W-1:0];
            REG_SRC_X:       cfg_mirror.src_x = val[OFS_W-1:0];
            REG_SRC_Y:       cfg_mirror.src_y = val[OFS_W-1:0];
            REG_DEST_X:      cfg_mirror.dest_x = val[DEST_W-1:0];
            REG_DEST_Y:      cfg_mirror.dest_y = val[DEST_W-1:0];
            REG_SCALE:       cfg_mirror.scale = val[SCALE_W-1:0];
            REG_LINE_PITCH:  cfg_mirror.line_pitch = val[PITCH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // one pixel transfer, called and left at a falling edge
    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row, input bit known,
                              input logic [ADDR_BITS-1:0] src, input logic [ADDR_BITS-1:0] dst);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_axis_tdata = IN_W'({row, col});
        cur_known = known;
        cur_src = src;
        cur_dst = dst;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // random register value: extremes, any field value, or a typical one; junk above the field
    function automatic logic [31:0] rand_reg_value(input logic [2:0] idx);
        int          pick;
        int          fw;
        logic [31:0] v;
        pick = $urandom_range(0, 7);
        case (idx)
            REG_ORIG_WIDTH: begin
                fw = WIDTH_W;
                v = pick == 0 ? 4 : pick == 1 ? 1024 : pick == 2 ? $urandom_range(0, 2047)
                  : 4 * $urandom_range(1, 256);
            end
            REG_ORIG_HEIGHT: begin
                fw = HEIGHT_W;
                v = pick == 0 ? 1 : pick == 1 ? 1024 : pick == 2 ? $urandom_range(0, 2047)
                  : $urandom_range(1, 1024);
            end
            REG_SRC_X, REG_SRC_Y: begin
                fw = OFS_W;
                v = pick == 0 ? 0 : pick == 1 ? 1023 : $urandom_range(0, 1023);
            end
            REG_DEST_X, REG_DEST_Y: begin
                fw = DEST_W;
                v = pick == 0 ? 0 : pick == 1 ? 4095 : $urandom_range(0, 4095);
            end
            REG_SCALE: begin
                fw = SCALE_W;
                v = pick == 0 ? 1 : pick == 1 ? 7 : pick == 2 ? $urandom_range(0, 7)
                  : $urandom_range(1, 4);
            end
            default: begin
                fw = PITCH_W;
                v = pick == 0 ? 1 : pick == 1 ? 4096 : pick == 2 ? $urandom_range(0, 8191)
                  : $urandom_range(1, 4096);
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            v = v | ($urandom << fw);
        end
        return v;
    endfunction

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        cur_known = 1'b0;
        cur_src = '0;
        cur_dst = '0;
        no_idle = 1'b0;
        mismatch_count = 0;
        cfg_mirror = '{orig_width: 320, orig_height: 200, src_x: 0, src_y: 0,
                       dest_x: 0, dest_y: 0, scale: 1, line_pitch: 320};

        // reset defaults first with known addresses, then each register to its corners
        dir_table = '{
            '{ROW_PIXEL, REG_SCALE, 0, 0, 0, 1, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 1, 0, 1, 16000, 1},
            '{ROW_PIXEL, REG_SCALE, 0, 3, 1, 1, 48080, 323},
            '{ROW_PIXEL, REG_SCALE, 0, 1023, 1023, 1, 130095, 328383},
            // scale zero acts as one
            '{ROW_WRITE, REG_SCALE, 0, 0, 0, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 2, 0, 1, 32000, 2},
            '{ROW_WRITE, REG_SCALE, 7, 0, 0, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 1023, 1023, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 0, 0, 0, 0, 0},
            // width off the four-pixel grid, zero height, maximum offsets
            '{ROW_WRITE, REG_ORIG_WIDTH, 2047, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_ORIG_HEIGHT, 0, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_SRC_X, 1023, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_SRC_Y, 1023, 0, 0, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 1023, 1023, 0, 0, 0},
            // destination corner and pitch high enough to wrap the address
            '{ROW_WRITE, REG_DEST_X, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_DEST_Y, 4095, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_LINE_PITCH, 8191, 0, 0, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 1023, 1023, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 0, 0, 0, 0, 0},
            // zero pitch, zero width, widest height
            '{ROW_WRITE, REG_LINE_PITCH, 0, 0, 0, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 512, 341, 0, 0, 0},
            '{ROW_WRITE, REG_ORIG_WIDTH, 0, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_ORIG_HEIGHT, 2047, 0, 0, 0, 0, 0},
            '{ROW_WRITE, REG_SCALE, 3, 0, 0, 0, 0, 0},
            '{ROW_PIXEL, REG_SCALE, 0, 10'h2AA, 10'h155, 0, 0, 0}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed rows
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_WRITE) begin
                drain_outputs();
                write_reg(dir_table[i].reg_idx, dir_table[i].value);
            end else begin
                send_pixel(dir_table[i].col, dir_table[i].row, dir_table[i].known,
                           dir_table[i].src_addr, dir_table[i].dst_addr);
            end
        end

        // random phases: fresh settings, then random pixels
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_outputs();
            for (int r = 0; r < 8; r++) begin
                write_reg(3'(r), rand_reg_value(3'(r)));
            end
            no_idle = (p == 5);
            for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
                if (p == 3 && k == PIXELS_PER_PHASE / 2) begin
                    // hold off until the block has gone quiet
                    i_s_axis_tvalid = 1'b0;
                    while (pending_addrs.size() != 0) begin
                        @(negedge i_clk);
                    end
                end
                send_pixel(10'($urandom), 10'($urandom), 1'b0, '0, '0);
            end
        end
        no_idle = 1'b0;
        drain_outputs();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
